// ----- rtl/closest_points_between_lines_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the closest points block
// Property wrappers used by the RTL file that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINTS_BETWEEN_LINES_DEFINES_SVH
`define CLOSEST_POINTS_BETWEEN_LINES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cpl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_pkg
// Widths, types and codes shared by the closest points front end, queue and
// solver.
// ----------------------------------------------------------------------------
package cpl_pkg;

    localparam int CW     = 24;                     // coordinate bits, Q12.12
    localparam int FW     = 16;                     // fraction bits of s and t
    localparam int DW     = CW + 1;                 // direction / offset bits
    localparam int PW     = 2 * DW;                 // one exact product
    localparam int DOTW   = PW + 2;                 // dot product of three terms
    localparam int DIG    = 16;                     // multiplier digit width
    localparam int NDIG   = (DOTW + DIG - 1) / DIG; // digits per operand
    localparam int YW     = NDIG * DIG;
    localparam int KW     = $clog2(NDIG);
    localparam int ACCW   = 2 * DOTW + 1;           // difference of two products
    localparam int DENW   = ACCW - 1;               // positive divisor
    localparam int NMAGW  = ACCW + FW;              // dividend magnitude
    localparam int QB     = CW + FW + 2;            // quotient bits produced
    localparam int NHW    = NMAGW - QB;
    localparam int SW     = CW + FW + 3;            // signed s and t
    localparam int THRW   = 32;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic signed [CW-1:0]   t_coord;
    typedef logic signed [DW-1:0]   t_dir;
    typedef logic signed [DOTW-1:0] t_dot;

    typedef enum logic [2:0] {
        CASE_GENERAL  = 3'd0,
        CASE_PARALLEL = 3'd1,
        CASE_DEG1     = 3'd2,
        CASE_DEG2     = 3'd3,
        CASE_BOTH     = 3'd4
    } t_case;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_SETUP,
        ST_DIV,
        ST_POINT,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        t_coord [2:0] p1;
        t_coord [2:0] p2;
        t_dir   [2:0] d1;
        t_dir   [2:0] d2;
        t_dot         a;
        t_dot         e;
        t_dot         b;
        t_dot         c;
        t_dot         f;
        t_case        code;
    } t_job;

    typedef struct packed {
        t_coord [2:0] near1;
        t_coord [2:0] near2;
        t_case        code;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef struct packed {
        logic          busy;
        logic          ovf;
        logic          rem_nz;
        logic [QB-1:0] q;
    } t_div_res;

endpackage

// ----- rtl/cpl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_front
// Three-stage front end: differences, exact products, dot products and
// degeneracy classification against the threshold register.
// ----------------------------------------------------------------------------
module cpl_front import cpl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [THRW-1:0] i_cfg_data,
    input  logic            i_push,
    output logic            o_full,
    input  t_coord [2:0]    i_p1,
    input  t_coord [2:0]    i_q1,
    input  t_coord [2:0]    i_p2,
    input  t_coord [2:0]    i_q2,
    input  logic            i_fifo_full,
    output logic            o_job_push,
    output t_job            o_job
);

    logic            r_thr;
    logic [THRW-1:0] r_thr_val;
    logic            w_en;

    logic         r1_v;
    t_coord [2:0] r1_p1, r1_p2;
    t_dir   [2:0] r1_d1, r1_d2, r1_r;

    logic         r2_v;
    t_coord [2:0] r2_p1, r2_p2;
    t_dir   [2:0] r2_d1, r2_d2;
    logic signed [PW-1:0] r2_prod [5][3];
    logic signed [PW-1:0] w_prod  [5][3];

    logic r3_v;
    t_job r3_job;
    t_dot w_a, w_e, w_b, w_c, w_f;
    logic w_deg1, w_deg2;

    function automatic t_dot f_sum3(input logic signed [PW-1:0] x0,
                                    input logic signed [PW-1:0] x1,
                                    input logic signed [PW-1:0] x2);
        return DOTW'(x0) + DOTW'(x1) + DOTW'(x2);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_en        = !r3_v || !i_fifo_full;
    assign o_full      = !w_en;
    assign o_job_push  = r3_v && !i_fifo_full;
    assign o_job       = r3_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_val <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr_val <= i_cfg_data;
        end
    end
    assign r_thr = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_push;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[0][k] = $signed(r1_d1[k]) * $signed(r1_d1[k]);
            w_prod[1][k] = $signed(r1_d2[k]) * $signed(r1_d2[k]);
            w_prod[2][k] = $signed(r1_d2[k]) * $signed(r1_r[k]);
            w_prod[3][k] = $signed(r1_d1[k]) * $signed(r1_r[k]);
            w_prod[4][k] = $signed(r1_d1[k]) * $signed(r1_d2[k]);
        end
    end

    always_comb begin
        w_a    = f_sum3(r2_prod[0][0], r2_prod[0][1], r2_prod[0][2]);
        w_e    = f_sum3(r2_prod[1][0], r2_prod[1][1], r2_prod[1][2]);
        w_f    = f_sum3(r2_prod[2][0], r2_prod[2][1], r2_prod[2][2]);
        w_c    = f_sum3(r2_prod[3][0], r2_prod[3][1], r2_prod[3][2]);
        w_b    = f_sum3(r2_prod[4][0], r2_prod[4][1], r2_prod[4][2]);
        w_deg1 = w_a <= $signed({{(DOTW-THRW){r_thr}}, r_thr_val});
        w_deg2 = w_e <= $signed({{(DOTW-THRW){r_thr}}, r_thr_val});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_p1[k] <= i_p1[k];
                r1_p2[k] <= i_p2[k];
                r1_d1[k] <= DW'($signed(i_q1[k])) - DW'($signed(i_p1[k]));
                r1_d2[k] <= DW'($signed(i_q2[k])) - DW'($signed(i_p2[k]));
                r1_r[k]  <= DW'($signed(i_p1[k])) - DW'($signed(i_p2[k]));
            end
            r2_p1 <= r1_p1;
            r2_p2 <= r1_p2;
            r2_d1 <= r1_d1;
            r2_d2 <= r1_d2;
            r2_prod <= w_prod;
            r3_job.p1 <= r2_p1;
            r3_job.p2 <= r2_p2;
            r3_job.d1 <= r2_d1;
            r3_job.d2 <= r2_d2;
            r3_job.a  <= w_a;
            r3_job.e  <= w_e;
            r3_job.b  <= w_b;
            r3_job.c  <= w_c;
            r3_job.f  <= w_f;
            if (w_deg1 && w_deg2) begin
                r3_job.code <= CASE_BOTH;
            end else if (w_deg1) begin
                r3_job.code <= CASE_DEG1;
            end else if (w_deg2) begin
                r3_job.code <= CASE_DEG2;
            end else begin
                r3_job.code <= CASE_GENERAL;
            end
        end
    end

endmodule

// ----- rtl/cpl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_fifo
// Short job queue between the front end and the solver, registered read.
// ----------------------------------------------------------------------------
module cpl_fifo import cpl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_job       i_wdata,
    input  logic       i_rd,
    output t_job       o_rdata,
    output t_fifo_stat o_stat
);

    t_job         r_mem [QDEPTH];
    t_job         r_rdata;
    logic [QAW:0] r_wp, r_rp;

    assign o_stat.empty = (r_wp == r_rp);
    assign o_stat.full  = (r_wp[QAW] != r_rp[QAW]) && (r_wp[QAW-1:0] == r_rp[QAW-1:0]);
    assign o_rdata      = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp[QAW-1:0]] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[r_rp[QAW-1:0]];
        end
    end

endmodule

// ----- rtl/cpl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_div
// Restoring divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module cpl_div import cpl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NMAGW-1:0] i_num,
    input  logic [DENW-1:0]  i_den,
    output t_div_res         o_res
);

    localparam int CNTW = $clog2(QB + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [DENW-1:0] r_rem, r_den;
    logic [QB-1:0]   r_low, r_q;
    logic            r_ovf;
    logic [DENW:0]   w_trial, w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_low[QB-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    assign o_res.busy   = r_busy;
    assign o_res.ovf    = r_ovf;
    assign o_res.rem_nz = |r_rem;
    assign o_res.q      = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNTW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNTW'(QB);
            r_rem <= DENW'(i_num[NMAGW-1:QB]);
            r_low <= i_num[QB-1:0];
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= {{(DENW-NHW){1'b0}}, i_num[NMAGW-1:QB]} >= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? w_diff[DENW-1:0] : w_trial[DENW-1:0];
            r_low <= {r_low[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

endmodule

// ----- rtl/cpl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpl_back
// Solver: digit-serial products, two dividers for s and t, point update
// with saturation, and the result output register.
// ----------------------------------------------------------------------------
`include "closest_points_between_lines_defines.svh"

module cpl_back import cpl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_stat i_fifo_stat,
    output logic       o_rd,
    input  t_job       i_job,
    input  logic       i_pop,
    output logic       o_empty,
    output t_result    o_res
);

    localparam int PRW  = DOTW + DIG + 1;
    localparam int MHW  = DW + SW - SW / 2;
    localparam int MLW  = DW + SW / 2 + 1;
    localparam int LOB  = SW / 2;
    localparam int SUMW = MHW + LOB + 1;
    localparam logic [SW-1:0] LIM = SW'(1) << (CW + 1 + FW);
    localparam logic signed [SUMW-1:0] C_HI = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] C_LO = -C_HI - SUMW'(1);

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [KW:0] r_cnt;
    logic signed [ACCW-1:0] r_acc [3];
    logic signed [ACCW-1:0] w_acc_n [3];
    t_dot w_x1 [3], w_y1 [3], w_x2 [3], w_y2 [3];

    logic r_use_s, r_use_t, r_sneg, r_tneg;
    logic w_use_s, w_use_t;
    logic signed [ACCW-1:0] w_ns, w_nt;
    logic [DENW-1:0]  w_ds, w_dt;
    logic [ACCW-1:0]  w_ms, w_mt;
    t_case            w_code;
    logic             w_start_s, w_start_t;
    t_div_res         w_div_s, w_div_t;

    logic signed [SW-1:0]  r_s, r_t;
    logic [1:0]            r_k;
    logic                  r_ph;
    logic signed [MHW-1:0] r_m1h, r_m2h;
    logic signed [MLW-1:0] r_m1l, r_m2l;

    t_result r_res, r_out;
    logic    r_ov;
    logic    w_rd, w_load, w_pop_fire;

    function automatic logic signed [SW-1:0] f_qfinal(input logic [QB-1:0] q,
                                                      input logic rem_nz,
                                                      input logic ovf,
                                                      input logic neg);
        logic [SW-1:0] v;
        v = SW'(q) + SW'(rem_nz);
        if (ovf) begin
            return neg ? -LIM : LIM;
        end else if (!neg) begin
            return (SW'(q) > LIM) ? LIM : SW'(q);
        end else begin
            return (v > LIM) ? -LIM : -v;
        end
    endfunction

    function automatic t_coord f_point(input t_coord p,
                                       input logic signed [MHW-1:0] mh,
                                       input logic signed [MLW-1:0] ml);
        logic signed [SUMW-1:0] sum, v;
        sum = (SUMW'(mh) <<< LOB) + SUMW'(ml);
        v   = (sum >>> FW) + SUMW'(p);
        if (v > C_HI) begin
            v = C_HI;
        end else if (v < C_LO) begin
            v = C_LO;
        end
        return v[CW-1:0];
    endfunction

    assign w_pop_fire = i_pop && r_ov;
    assign o_empty    = !r_ov;
    assign o_res      = r_out;
    assign o_rd       = w_rd;

    // Operand pairs per lane: lane 0 a*e - b*b, lane 1 b*f - c*e, lane 2 a*f - b*c
    always_comb begin
        w_x1[0] = r_job.a; w_y1[0] = r_job.e; w_x2[0] = r_job.b; w_y2[0] = r_job.b;
        w_x1[1] = r_job.b; w_y1[1] = r_job.f; w_x2[1] = r_job.c; w_y2[1] = r_job.e;
        w_x1[2] = r_job.a; w_y1[2] = r_job.f; w_x2[2] = r_job.b; w_y2[2] = r_job.c;
    end

    always_comb begin
        logic [KW-1:0]          k;
        logic                   second;
        t_dot                   x;
        logic signed [YW-1:0]   yx;
        logic [DIG-1:0]         dig;
        logic signed [DIG:0]    dg;
        logic signed [PRW-1:0]  prod;
        logic signed [ACCW-1:0] term;
        k      = r_cnt[KW-1:0];
        second = r_cnt[KW];
        for (int l = 0; l < 3; l++) begin
            x    = second ? w_x2[l] : w_x1[l];
            yx   = YW'(second ? w_y2[l] : w_y1[l]);
            dig  = yx[DIG*k +: DIG];
            dg   = {(k == KW'(NDIG - 1)) && dig[DIG-1], dig};
            prod = x * dg;
            term = ACCW'(prod) << (k * DIG);
            w_acc_n[l] = second ? r_acc[l] - term : r_acc[l] + term;
        end
    end

    // Path decoder: picks dividends and divisors for s and t
    always_comb begin
        w_use_s = 1'b0;
        w_use_t = 1'b0;
        w_ns    = r_acc[1];
        w_nt    = r_acc[2];
        w_ds    = r_acc[0][DENW-1:0];
        w_dt    = r_acc[0][DENW-1:0];
        w_code  = r_job.code;
        unique case (r_job.code)
            CASE_BOTH: begin
            end
            CASE_DEG1: begin
                w_use_t = 1'b1;
                w_nt    = ACCW'(r_job.f);
                w_dt    = DENW'($unsigned(r_job.e));
            end
            CASE_DEG2: begin
                w_use_s = 1'b1;
                w_ns    = -ACCW'(r_job.c);
                w_ds    = DENW'($unsigned(r_job.a));
            end
            default: begin
                if (r_acc[0] == '0) begin
                    w_code  = CASE_PARALLEL;
                    w_use_t = 1'b1;
                    w_nt    = ACCW'(r_job.f);
                    w_dt    = DENW'($unsigned(r_job.e));
                end else begin
                    w_use_s = 1'b1;
                    w_use_t = 1'b1;
                end
            end
        endcase
        w_ms = w_ns[ACCW-1] ? -w_ns : w_ns;
        w_mt = w_nt[ACCW-1] ? -w_nt : w_nt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_rd      = 1'b0;
        w_load    = 1'b0;
        w_start_s = 1'b0;
        w_start_t = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    w_rd    = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_cnt == (KW + 1)'(2 * NDIG - 1)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                w_start_s = w_use_s;
                w_start_t = w_use_t;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (!w_div_s.busy && !w_div_t.busy) begin
                    n_state = ST_POINT;
                end
            end
            ST_POINT: begin
                if (r_ph && r_k == 2'd2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || w_pop_fire) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (w_pop_fire) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_job <= i_job;
                r_cnt <= '0;
                for (int l = 0; l < 3; l++) begin
                    r_acc[l] <= '0;
                end
            end
            ST_MAC: begin
                r_cnt <= r_cnt + 1'b1;
                for (int l = 0; l < 3; l++) begin
                    r_acc[l] <= w_acc_n[l];
                end
            end
            ST_SETUP: begin
                r_use_s    <= w_use_s;
                r_use_t    <= w_use_t;
                r_sneg     <= w_ns[ACCW-1];
                r_tneg     <= w_nt[ACCW-1];
                r_res.code <= w_code;
            end
            ST_DIV: begin
                r_s  <= r_use_s ? f_qfinal(w_div_s.q, w_div_s.rem_nz, w_div_s.ovf, r_sneg)
                                : '0;
                r_t  <= r_use_t ? f_qfinal(w_div_t.q, w_div_t.rem_nz, w_div_t.ovf, r_tneg)
                                : '0;
                r_k  <= '0;
                r_ph <= 1'b0;
            end
            ST_POINT: begin
                if (!r_ph) begin
                    r_m1h <= $signed(r_job.d1[r_k]) * $signed(r_s[SW-1:LOB]);
                    r_m1l <= $signed(r_job.d1[r_k]) * $signed({1'b0, r_s[LOB-1:0]});
                    r_m2h <= $signed(r_job.d2[r_k]) * $signed(r_t[SW-1:LOB]);
                    r_m2l <= $signed(r_job.d2[r_k]) * $signed({1'b0, r_t[LOB-1:0]});
                end else begin
                    r_res.near1[r_k] <= f_point(r_job.p1[r_k], r_m1h, r_m1l);
                    r_res.near2[r_k] <= f_point(r_job.p2[r_k], r_m2h, r_m2l);
                    r_k <= r_k + 1'b1;
                end
                r_ph <= !r_ph;
            end
            ST_DONE: begin
                if (w_load) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    cpl_div u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_s),
        .i_num   ({w_ms, {FW{1'b0}}}),
        .i_den   (w_ds),
        .o_res   (w_div_s)
    );

    cpl_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_t),
        .i_num   ({w_mt, {FW{1'b0}}}),
        .i_den   (w_dt),
        .o_res   (w_div_t)
    );

    `CPL_ASSERT_SAME(a_out_no_overwrite, i_clk, i_rst_n, w_load, (!r_ov || w_pop_fire), "result overwritten before it was taken")
    `CPL_ASSERT_SAME(a_out_leaves_on_pop, i_clk, i_rst_n, $fell(r_ov), $past(w_pop_fire), "result dropped without a pop")
    `CPL_ASSERT_SAME(a_div_quiet_in_idle, i_clk, i_rst_n, (r_state == ST_IDLE), (!w_div_s.busy && !w_div_t.busy), "divider running outside a job")

endmodule

// ----- rtl/closest_points_between_lines.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_points_between_lines
// Closest points on two infinite 3D lines, Q12.12 in and out, with a case code.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Words
// input     in         push / full        two lines, four points Q12.12
// result    out        empty / pop        two nearest points and case code
// config    in         valid / ready      degenerate threshold, 32 bits
//
// A front end of three pipeline stages forms the direction vectors, the
// exact dot products a, b, c, e and f, and flags degenerate lines. It takes
// one word per cycle while the four-entry job queue it feeds is not full.
// The solver works one job at a time: 16-bit digit products, a setup
// step, the two restoring dividers (one quotient bit per cycle, s and t
// in parallel) and the point updates. The dividers set the sustained rate.
// Reset is synchronous and active low; it empties the queue and the result
// register and clears the threshold to zero.
// The front end keeps accepting while the solver is busy until the queue
// fills; a result waiting in the output register only holds the solver.
//
// ----------------------------------------------------------------------------
module closest_points_between_lines import cpl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [THRW-1:0] i_cfg_data,

    input  logic            push,
    output logic            full,
    input  logic [CW-1:0]   i_line1_start_x,
    input  logic [CW-1:0]   i_line1_start_y,
    input  logic [CW-1:0]   i_line1_start_z,
    input  logic [CW-1:0]   i_line1_end_x,
    input  logic [CW-1:0]   i_line1_end_y,
    input  logic [CW-1:0]   i_line1_end_z,
    input  logic [CW-1:0]   i_line2_start_x,
    input  logic [CW-1:0]   i_line2_start_y,
    input  logic [CW-1:0]   i_line2_start_z,
    input  logic [CW-1:0]   i_line2_end_x,
    input  logic [CW-1:0]   i_line2_end_y,
    input  logic [CW-1:0]   i_line2_end_z,

    output logic            empty,
    input  logic            pop,
    output logic [CW-1:0]   o_near1_x,
    output logic [CW-1:0]   o_near1_y,
    output logic [CW-1:0]   o_near1_z,
    output logic [CW-1:0]   o_near2_x,
    output logic [CW-1:0]   o_near2_y,
    output logic [CW-1:0]   o_near2_z,
    output logic [2:0]      o_case_code
);

    t_coord [2:0] w_p1, w_q1, w_p2, w_q2;
    logic         w_job_push;
    t_job         w_job_in, w_job_out;
    logic         w_fifo_rd;
    t_fifo_stat   w_fifo_stat;
    t_result      w_res;

    // Coordinates are packed x, y, z from index 0 upwards.
    assign w_p1 = {i_line1_start_z, i_line1_start_y, i_line1_start_x};
    assign w_q1 = {i_line1_end_z,   i_line1_end_y,   i_line1_end_x};
    assign w_p2 = {i_line2_start_z, i_line2_start_y, i_line2_start_x};
    assign w_q2 = {i_line2_end_z,   i_line2_end_y,   i_line2_end_x};

    cpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_p1        (w_p1),
        .i_q1        (w_q1),
        .i_p2        (w_p2),
        .i_q2        (w_q2),
        .i_fifo_full (w_fifo_stat.full),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in)
    );

    cpl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_push),
        .i_wdata (w_job_in),
        .i_rd    (w_fifo_rd),
        .o_rdata (w_job_out),
        .o_stat  (w_fifo_stat)
    );

    cpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (w_fifo_stat),
        .o_rd        (w_fifo_rd),
        .i_job       (w_job_out),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    // The case code leaves as its raw three-bit encoding.
    assign o_near1_x   = w_res.near1[0];
    assign o_near1_y   = w_res.near1[1];
    assign o_near1_z   = w_res.near1[2];
    assign o_near2_x   = w_res.near2[0];
    assign o_near2_y   = w_res.near2[1];
    assign o_near2_z   = w_res.near2[2];
    assign o_case_code = w_res.code;

endmodule
